// ===== src/mhas_pkg.sv =====
// Shared constants, command codes and controller/datapath interface types.
package mhas_pkg;

  localparam int SEQ_LEN     = 128;
  localparam int NUM_HEADS   = 12;
  localparam int HEAD_DIM    = 64;
  localparam int ROW_LEN     = NUM_HEADS * HEAD_DIM;
  localparam int STORE_DEPTH = SEQ_LEN * ROW_LEN;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);

  // Field widths fixed by the interface.
  localparam int CMD_W   = 2;
  localparam int TOKEN_W = 7;
  localparam int FEAT_W  = 10;
  localparam int DATA_W  = 8;
  localparam int HEAD_W  = 4;
  localparam int SCORE_W = 22;

  // Feature offset counter inside one head slice.
  localparam int KW = (HEAD_DIM > 1) ? $clog2(HEAD_DIM) : 1;

  localparam int PROD_W = 2 * DATA_W;
  localparam int ACC_W  = (PROD_W + KW + 1 > SCORE_W + 1) ? PROD_W + KW + 1 : SCORE_W + 1;

  localparam int SCORE_MAX = 2097151;
  localparam int SCORE_MIN = -2097152;
  localparam logic signed [ACC_W-1:0] ACC_MAX = ACC_W'(SCORE_MAX);
  localparam logic signed [ACC_W-1:0] ACC_MIN = ACC_W'(SCORE_MIN);

  localparam logic [CMD_W-1:0] CMD_WR_Q  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_WR_K  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_SCORE = 2'd2;

  typedef struct packed {
    logic write_q;   // store request byte into query store
    logic write_k;   // store request byte into key store
    logic start;     // latch score bases, clear accumulator
    logic issue;     // read one byte pair, advance offset
    logic load_out;  // load output register from accumulator
  } mhas_cmd_t;

  typedef struct packed {
    logic skip;      // score request out of range, result is zero
    logic last;      // offset at final feature of the slice
    logic busy;      // MAC pipeline still holds data
  } mhas_stat_t;

endpackage

// ===== src/mhas_ctrl.sv =====
// Controller state machine: request handshake, score sequencing, output valid.
module mhas_ctrl (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [mhas_pkg::CMD_W-1:0]  in_command,
  output logic                        out_valid,
  input  logic                        out_ready,
  input  mhas_pkg::mhas_stat_t        stat,
  output mhas_pkg::mhas_cmd_t         cmd
);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_ISSUE  = 4'b0010,
    ST_DRAIN  = 4'b0100,
    ST_RESULT = 4'b1000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   accept;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign accept    = in_valid && in_ready;

  always_comb begin
    state_nxt     = state_r;
    cmd.write_q   = accept && (in_command == mhas_pkg::CMD_WR_Q);
    cmd.write_k   = accept && (in_command == mhas_pkg::CMD_WR_K);
    cmd.start     = accept && (in_command == mhas_pkg::CMD_SCORE);
    cmd.issue     = 1'b0;
    cmd.load_out  = 1'b0;
    out_valid_nxt = out_valid_r && !out_ready;
    unique case (state_r)
      ST_IDLE: begin
        if (cmd.start) state_nxt = ST_ISSUE;
      end
      ST_ISSUE: begin
        cmd.issue = !stat.skip;
        if (stat.skip) state_nxt = ST_RESULT;
        else if (stat.last) state_nxt = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (!stat.busy) state_nxt = ST_RESULT;
      end
      ST_RESULT: begin
        // wait for the output register to free up
        if (!out_valid_r || out_ready) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_score_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.start |=> !in_ready)
    else $error("score request did not close the input");

  a_load_from_result: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> (state_r == ST_RESULT) && !(out_valid_r && !out_ready))
    else $error("output loaded over a pending result");

endmodule

// ===== src/mhas_dp.sv =====
// Datapath: query/key byte stores, slice address walk, MAC pipeline, output register.
module mhas_dp (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  mhas_pkg::mhas_cmd_t                  cmd,
  output mhas_pkg::mhas_stat_t                 stat,
  input  logic [mhas_pkg::TOKEN_W-1:0]         in_token,
  input  logic [mhas_pkg::FEAT_W-1:0]          in_feature,
  input  logic signed [mhas_pkg::DATA_W-1:0]   in_data,
  input  logic [mhas_pkg::HEAD_W-1:0]          in_head,
  input  logic [mhas_pkg::TOKEN_W-1:0]         in_query_row,
  input  logic [mhas_pkg::TOKEN_W-1:0]         in_key_column,
  output logic signed [mhas_pkg::SCORE_W-1:0]  out_score
);

  localparam int AW = mhas_pkg::ADDR_W;
  localparam int KW = mhas_pkg::KW;
  localparam int DW = mhas_pkg::DATA_W;

  logic signed [DW-1:0] q_mem [mhas_pkg::STORE_DEPTH];
  logic signed [DW-1:0] k_mem [mhas_pkg::STORE_DEPTH];

  logic                 in_range_wr;
  logic [AW-1:0]        wr_addr;
  logic [AW-1:0]        head_off;
  logic [AW-1:0]        qbase_nxt, kbase_nxt;
  logic                 skip_nxt;

  logic [AW-1:0]        qbase_r, kbase_r;
  logic                 skip_r;
  logic [KW-1:0]        k_r;
  logic [AW-1:0]        q_addr, k_addr;

  logic signed [DW-1:0]                      q_rd_r, k_rd_r;
  logic signed [mhas_pkg::PROD_W-1:0]        prod_r;
  logic signed [mhas_pkg::ACC_W-1:0]         acc_r;
  logic                                      v1_r, v2_r;
  logic signed [mhas_pkg::SCORE_W-1:0]       score_r, sat_score;

  // write side: token * ROW_LEN + feature, out-of-range writes dropped
  assign in_range_wr = (32'(in_token) < mhas_pkg::SEQ_LEN) &&
                       (32'(in_feature) < mhas_pkg::ROW_LEN);
  assign wr_addr = AW'(in_token) * AW'(mhas_pkg::ROW_LEN) + AW'(in_feature);

  // score bases
  assign head_off  = AW'(in_head) * AW'(mhas_pkg::HEAD_DIM);
  assign qbase_nxt = AW'(in_query_row) * AW'(mhas_pkg::ROW_LEN) + head_off;
  assign kbase_nxt = AW'(in_key_column) * AW'(mhas_pkg::ROW_LEN) + head_off;
  assign skip_nxt  = (32'(in_head) >= mhas_pkg::NUM_HEADS) ||
                     (32'(in_query_row) >= mhas_pkg::SEQ_LEN) ||
                     (32'(in_key_column) >= mhas_pkg::SEQ_LEN);

  assign q_addr = qbase_r + AW'(k_r);
  assign k_addr = kbase_r + AW'(k_r);

  always_ff @(posedge clk) begin
    if (cmd.write_q && in_range_wr) q_mem[wr_addr] <= in_data;
    if (cmd.issue) q_rd_r <= q_mem[q_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.write_k && in_range_wr) k_mem[wr_addr] <= in_data;
    if (cmd.issue) k_rd_r <= k_mem[k_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      qbase_r <= qbase_nxt;
      kbase_r <= kbase_nxt;
      skip_r  <= skip_nxt;
      k_r     <= '0;
    end else if (cmd.issue) begin
      k_r <= k_r + KW'(1);
    end
  end

  // MAC: read -> multiply -> accumulate
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= cmd.issue;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (v1_r) prod_r <= q_rd_r * k_rd_r;
    if (cmd.start) acc_r <= '0;
    else if (v2_r) acc_r <= acc_r + mhas_pkg::ACC_W'(prod_r);
  end

  always_comb begin
    if (acc_r > mhas_pkg::ACC_MAX) sat_score = mhas_pkg::SCORE_W'(mhas_pkg::ACC_MAX);
    else if (acc_r < mhas_pkg::ACC_MIN) sat_score = mhas_pkg::SCORE_W'(mhas_pkg::ACC_MIN);
    else sat_score = acc_r[mhas_pkg::SCORE_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) score_r <= skip_r ? '0 : sat_score;
  end

  assign out_score = score_r;

  assign stat.skip = skip_r;
  assign stat.last = (k_r == KW'(mhas_pkg::HEAD_DIM - 1));
  assign stat.busy = v1_r || v2_r;

  a_no_issue_on_skip: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.issue |-> !skip_r)
    else $error("store read issued for an out-of-range score");

  a_load_after_drain: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> !v1_r && !v2_r)
    else $error("result taken before MAC pipeline drained");

  a_start_idle_pipe: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.start |-> !v1_r && !v2_r && !cmd.issue)
    else $error("new score started over a running one");

endmodule

// ===== src/multihead_attention_scores.sv =====
// Top level: int8 multi-head attention query-key score unit.
//
//   channel | ports                                             | dir
//   --------+---------------------------------------------------+-----
//   request | in_valid/in_ready, in_command, in_token,           | in
//           | in_feature, in_data, in_head, in_query_row,        |
//           | in_key_column                                      |
//   result  | out_valid/out_ready, out_score                     | out
//
// Byte writes (query or key) leave the controller idle; in_ready stays high.
// A score request does one multiply-accumulate per feature of the head slice,
// one byte pair a cycle from the single read port of each store, through the
// read, multiply and accumulate registers. Out-of-range scores skip the reads.
// Synchronous active-low reset clears control only; stores are not cleared.
// A result held on a stalled output does not block new requests; a finished
// score waits in the controller until the output register is free.
module multihead_attention_scores (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [mhas_pkg::CMD_W-1:0]           in_command,
  input  logic [mhas_pkg::TOKEN_W-1:0]         in_token,
  input  logic [mhas_pkg::FEAT_W-1:0]          in_feature,
  input  logic signed [mhas_pkg::DATA_W-1:0]   in_data,
  input  logic [mhas_pkg::HEAD_W-1:0]          in_head,
  input  logic [mhas_pkg::TOKEN_W-1:0]         in_query_row,
  input  logic [mhas_pkg::TOKEN_W-1:0]         in_key_column,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [mhas_pkg::SCORE_W-1:0]  out_score
);

  mhas_pkg::mhas_cmd_t  cmd;
  mhas_pkg::mhas_stat_t stat;

  mhas_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_command (in_command),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .stat       (stat),
    .cmd        (cmd)
  );

  mhas_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .stat          (stat),
    .in_token      (in_token),
    .in_feature    (in_feature),
    .in_data       (in_data),
    .in_head       (in_head),
    .in_query_row  (in_query_row),
    .in_key_column (in_key_column),
    .out_score     (out_score)
  );

endmodule
